[hdl/bpd_pkg.sv]
package bpd_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam logic [2:0] CMD_INS_HEAD = 3'd0;
    localparam logic [2:0] CMD_INS_TAIL = 3'd1;
    localparam logic [2:0] CMD_REM_HEAD = 3'd2;
    localparam logic [2:0] CMD_REM_TAIL = 3'd3;
    localparam logic [2:0] CMD_RD_HEAD  = 3'd4;
    localparam logic [2:0] CMD_RD_TAIL  = 3'd5;
    localparam logic [2:0] CMD_RD_INDEX = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam int REC_W = 24;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] pos_symbol;
        logic [7:0] entry_index;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] out_x;
        logic [7:0] out_y;
        logic [7:0] out_symbol;
        logic [8:0] fill_count;
        logic [1:0] status;
    } result_word_t;

endpackage

[hdl/bounded_position_deque_top.sv]
// Bounded double-ended queue of position records (x, y, symbol) held in a
// circular single-port RAM of CAPACITY entries, tracked by a head pointer and
// a record count. A command word is taken on any cycle with start high; busy
// is never raised, so the block sustains one command per clock. Each command
// returns exactly one result word, with strobe high for one cycle, on the
// cycle after it was taken: the RAM address is formed from the command and
// the head/count registers at the accepting edge and the RAM's registered
// read port supplies the record. The receiver cannot stall, so results must
// be consumed as they appear. Record fields are zero unless a read succeeds;
// status reports full, empty or index out of range, and in those cases the
// state is left unchanged. No clearing pass after reset.
module bounded_position_deque_top #(
    parameter int CAPACITY = bpd_pkg::CAPACITY_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  bpd_pkg::cmd_word_t    item,
    output logic                  strobe,
    output bpd_pkg::result_word_t result
);
    import bpd_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 8) ? CW : 8;
    localparam int SW = AW + 1;

    logic [REC_W-1:0] mem [CAPACITY];
    logic [REC_W-1:0] mem_q;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          strobe_reg;
    logic          rd_ok_reg, rd_ok_next;
    logic [8:0]    fill_reg;
    logic [1:0]    status_reg, status_next;

    logic          accept;
    logic          is_full, is_empty;
    logic [AW-1:0] offset;
    logic [SW-1:0] slot_sum;
    logic [AW-1:0] slot;
    logic [AW-1:0] head_dec, head_inc;
    logic [AW-1:0] addr;
    logic          we, re;
    logic [IW-1:0] idx_ext, count_ext;

    assign accept   = start;
    assign busy     = 1'b0;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign idx_ext   = IW'(item.entry_index);
    assign count_ext = IW'(count_reg);

    assign head_dec = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + AW'(1);

    // offset from head for the slot this command touches
    always_comb
    begin
        case (item.cmd)
            CMD_INS_TAIL: offset = AW'(count_reg);
            CMD_RD_TAIL:  offset = AW'(count_reg - CW'(1));
            CMD_RD_INDEX: offset = AW'(idx_ext);
            default:      offset = '0;
        endcase
    end

    // head + offset, wrapped once; both operands are below CAPACITY
    assign slot_sum = SW'(head_reg) + SW'(offset);
    assign slot     = (slot_sum >= SW'(CAPACITY)) ? AW'(slot_sum - SW'(CAPACITY))
                                                  : AW'(slot_sum);

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        addr        = slot;
        we          = 1'b0;
        re          = 1'b0;
        case (item.cmd)
            CMD_INS_HEAD:
            begin
                addr = head_dec;
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_INS_TAIL:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_REM_HEAD:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_REM_TAIL:
            begin
                if (is_empty)
                    status_next = ST_EMPTY;
                else
                    count_next = count_reg - CW'(1);
            end
            CMD_RD_HEAD:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    re         = 1'b1;
                    rd_ok_next = 1'b1;
                end
            end
            CMD_RD_TAIL:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    re         = 1'b1;
                    rd_ok_next = 1'b1;
                end
            end
            CMD_RD_INDEX:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (idx_ext >= count_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    re         = 1'b1;
                    rd_ok_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // single-port RAM, registered read
    always_ff @(posedge clk)
    begin
        if (accept && we)
            mem[addr] <= {item.pos_x, item.pos_y, item.pos_symbol};
        if (accept && re)
            mem_q <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            rd_ok_reg  <= 1'b0;
            fill_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            strobe_reg <= accept;
            if (accept)
            begin
                head_reg   <= head_next;
                count_reg  <= count_next;
                rd_ok_reg  <= rd_ok_next;
                fill_reg   <= 9'(count_next);
                status_reg <= status_next;
            end
        end
    end

    assign strobe            = strobe_reg;
    assign result.out_x      = rd_ok_reg ? mem_q[23:16] : 8'd0;
    assign result.out_y      = rd_ok_reg ? mem_q[15:8]  : 8'd0;
    assign result.out_symbol = rd_ok_reg ? mem_q[7:0]   : 8'd0;
    assign result.fill_count = fill_reg;
    assign result.status     = status_reg;

endmodule

[tb/sv/bounded_position_deque_top_tb.sv]
module bounded_position_deque_top_tb;
    import bpd_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_WORDS = 1530;
    localparam int SHOW_LIMIT = 10;

    typedef enum int {GROW, DRAIN, CHURN} load_mode_t;

    // Mirrors the circular record store; one expected result word per command.
    class deque_scoreboard;
        logic [23:0]  slots [CAP];
        int unsigned  head_slot;
        int unsigned  live_count;
        result_word_t awaited [$];
        int unsigned  errors;

        function new();
            head_slot = 0;
            live_count = 0;
            errors = 0;
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t: %s", $time, what);
        endfunction

        function void note_command(cmd_word_t w);
            result_word_t e;
            bit           hit;
            int unsigned  offset;
            e = '0;
            hit = 0;
            offset = 0;
            case (w.cmd)
                CMD_INS_HEAD:
                    if (live_count >= CAP)
                        e.status = ST_FULL;
                    else
                    begin
                        head_slot = (head_slot + CAP - 1) % CAP;
                        slots[head_slot] = {w.pos_x, w.pos_y, w.pos_symbol};
                        live_count++;
                    end
                CMD_INS_TAIL:
                    if (live_count >= CAP)
                        e.status = ST_FULL;
                    else
                    begin
                        slots[(head_slot + live_count) % CAP] = {w.pos_x, w.pos_y, w.pos_symbol};
                        live_count++;
                    end
                CMD_REM_HEAD:
                    if (live_count == 0)
                        e.status = ST_EMPTY;
                    else
                    begin
                        head_slot = (head_slot + 1) % CAP;
                        live_count--;
                    end
                CMD_REM_TAIL:
                    if (live_count == 0)
                        e.status = ST_EMPTY;
                    else
                        live_count--;
                CMD_RD_HEAD:
                    if (live_count == 0)
                        e.status = ST_EMPTY;
                    else
                        hit = 1;
                CMD_RD_TAIL:
                    if (live_count == 0)
                        e.status = ST_EMPTY;
                    else
                    begin
                        hit = 1;
                        offset = live_count - 1;
                    end
                CMD_RD_INDEX:
                    if (live_count == 0)
                        e.status = ST_EMPTY;
                    else if (32'(w.entry_index) >= live_count)
                        e.status = ST_RANGE;
                    else
                    begin
                        hit = 1;
                        offset = 32'(w.entry_index);
                    end
                default: ;  // unused code: no effect, ok status
            endcase
            if (hit)
                {e.out_x, e.out_y, e.out_symbol} = slots[(head_slot + offset) % CAP];
            e.fill_count = live_count[8:0];
            awaited.push_back(e);
        endfunction

        function void check_result(result_word_t got);
            result_word_t e;
            if (awaited.size() == 0)
                flag($sformatf("unexpected result word %h", got));
            else
            begin
                e = awaited.pop_front();
                if (got.out_x !== e.out_x || got.out_y !== e.out_y
                    || got.out_symbol !== e.out_symbol
                    || got.fill_count !== e.fill_count || got.status !== e.status)
                    flag($sformatf({"mismatch: expected x=%h y=%h sym=%h fill=%0d st=%0d,",
                                    " got x=%h y=%h sym=%h fill=%0d st=%0d"},
                                   e.out_x, e.out_y, e.out_symbol, e.fill_count, e.status,
                                   got.out_x, got.out_y, got.out_symbol, got.fill_count,
                                   got.status));
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic         busy;
    cmd_word_t    item;
    logic         strobe;
    result_word_t result;

    deque_scoreboard sb = new();
    load_mode_t      mode;
    int unsigned     n;
    int unsigned     dwell;
    int unsigned     drain_wait;

    bounded_position_deque_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(item);
            if (strobe)
                sb.check_result(result);
        end
    end

    function automatic cmd_word_t compose(logic [2:0] c, logic [7:0] x, logic [7:0] y,
                                          logic [7:0] sym, logic [7:0] idx);
        cmd_word_t w;
        w.cmd = c;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_symbol = sym;
        w.entry_index = idx;
        return w;
    endfunction

    function automatic cmd_word_t random_word(load_mode_t m);
        cmd_word_t   w;
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned rem_pct;
        int unsigned rd_pct;
        int unsigned held;
        held = sb.live_count;
        case (m)
            GROW:    begin ins_pct = 80; rem_pct = 6;  rd_pct = 12; end
            DRAIN:   begin ins_pct = 8;  rem_pct = 72; rd_pct = 18; end
            default: begin ins_pct = 40; rem_pct = 30; rd_pct = 28; end
        endcase
        w.pos_x = 8'($urandom_range(0, 255));
        w.pos_y = 8'($urandom_range(0, 255));
        w.pos_symbol = 8'($urandom_range(0, 255));
        w.entry_index = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            w.cmd = $urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL;
        else if (roll < ins_pct + rem_pct)
            w.cmd = $urandom_range(0, 1) ? CMD_REM_HEAD : CMD_REM_TAIL;
        else if (roll < ins_pct + rem_pct + rd_pct)
        begin
            case ($urandom_range(0, 3))
                0:       w.cmd = CMD_RD_HEAD;
                1:       w.cmd = CMD_RD_TAIL;
                default: w.cmd = CMD_RD_INDEX;
            endcase
            // mostly live indexes, some past the end
            if (held > 0 && $urandom_range(0, 3) != 0)
                w.entry_index = 8'($urandom_range(0, held - 1));
        end
        else
            w.cmd = CMD_UNUSED;
        return w;
    endfunction

    function automatic int unsigned pick_gap(int unsigned k);
        int unsigned roll;
        if (k % 300 < 60)
            return 0;  // back-to-back stretch
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_word(cmd_word_t w, int unsigned gap);
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, unused code, pointer wrap, index bounds
        send_word(compose(CMD_RD_HEAD,  8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_RD_TAIL,  8'hff, 8'hff, 8'hff, 8'hff), $urandom_range(0, 2));
        send_word(compose(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_UNUSED,   8'hff, 8'hff, 8'hff, 8'hff), $urandom_range(0, 2));
        send_word(compose(CMD_INS_TAIL, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_INS_HEAD, 8'hff, 8'hff, 8'hff, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_INS_TAIL, 8'ha5, 8'h5a, 8'h3c, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_RD_HEAD,  8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_RD_TAIL,  8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h02), $urandom_range(0, 2));
        send_word(compose(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h03), $urandom_range(0, 2));
        send_word(compose(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'hff), $urandom_range(0, 2));
        send_word(compose(CMD_UNUSED,   8'h12, 8'h34, 8'h56, 8'h01), $urandom_range(0, 2));
        send_word(compose(CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_RD_HEAD,  8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_RD_TAIL,  8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));
        send_word(compose(CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00), $urandom_range(0, 2));

        // fill to capacity and sit there, drain to empty and sit there, then mix
        mode = GROW;
        dwell = 0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            send_word(random_word(mode), pick_gap(n));
            case (mode)
                GROW:
                    if (sb.live_count == CAP)
                    begin
                        dwell++;
                        if (dwell >= 30)
                        begin
                            mode = DRAIN;
                            dwell = 0;
                        end
                    end
                DRAIN:
                    if (sb.live_count == 0)
                    begin
                        dwell++;
                        if (dwell >= 20)
                        begin
                            mode = CHURN;
                            dwell = 0;
                        end
                    end
                default:
                begin
                    dwell++;
                    if (dwell >= 150)
                    begin
                        mode = GROW;
                        dwell = 0;
                    end
                end
            endcase
            if (n % 400 == 399)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (sb.awaited.size() != 0)
                    @(posedge clk);
            end
        end
        start <= 1'b0;

        drain_wait = 0;
        while (sb.awaited.size() != 0 && drain_wait < 1000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (8) @(posedge clk);
        if (sb.awaited.size() != 0)
            sb.flag($sformatf("%0d result words never arrived", sb.awaited.size()));

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
